// ----- design/pte_pkg.sv -----
package pte_pkg;

	// Field and datapath widths.
	localparam int CH_W  = 8;
	localparam int SEL_W = 4;
	localparam int OUT_W = 24;
	// Numerator: at most four channels summed (1020).
	localparam int NUM_W = 10;
	// Denominator: at most 510.
	localparam int DEN_W = 9;

	localparam int FRAC_BITS_DEFAULT = 16;

	// Quotient bits that the divider resolves in one pipeline stage.
	localparam int DIV_BPS = 4;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam logic [DEN_W-1:0] DEN_CH   = DEN_W'(255);
	localparam logic [DEN_W-1:0] DEN_GA   = DEN_W'(2);
	localparam logic [DEN_W-1:0] DEN_RGB  = DEN_W'(3);
	localparam logic [DEN_W-1:0] DEN_RGBA = DEN_W'(4);
	localparam logic [DEN_W-1:0] DEN_LIT  = DEN_W'(510);
	localparam logic [DEN_W-1:0] DEN_ONE  = DEN_W'(1);

	typedef enum logic [SEL_W-1:0] {
		TRAIT_CH0  = 4'd0,
		TRAIT_CH1  = 4'd1,
		TRAIT_CH2  = 4'd2,
		TRAIT_CH3  = 4'd3,
		TRAIT_GA   = 4'd4,
		TRAIT_RGB  = 4'd5,
		TRAIT_RGBA = 4'd6,
		TRAIT_LIT  = 4'd7,
		TRAIT_SAT  = 4'd8
	} trait_t;

	// Side information that rides along with every word.
	typedef struct packed {
		logic flag;
		logic last;
	} ctl_t;

endpackage

// ----- design/pte_prep.sv -----
module pte_prep #(
	parameter int FRAC_BITS = pte_pkg::FRAC_BITS_DEFAULT,
	parameter int DW        = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic [pte_pkg::CH_W-1:0]    ch0,
	input  logic [pte_pkg::CH_W-1:0]    ch1,
	input  logic [pte_pkg::CH_W-1:0]    ch2,
	input  logic [pte_pkg::CH_W-1:0]    ch3,
	input  logic                        last_pixel,
	input  logic [pte_pkg::SEL_W-1:0]   sel,
	output logic                        valid_s1,
	output logic [DW-1:0]               dividend_s1,
	output logic [pte_pkg::DEN_W-1:0]   den_s1,
	output pte_pkg::ctl_t               ctl_s1
);

	logic [pte_pkg::CH_W-1:0]  hi;
	logic [pte_pkg::CH_W-1:0]  lo;
	logic [pte_pkg::NUM_W-1:0] num;
	logic [pte_pkg::DEN_W-1:0] den;
	logic                      flag;

	// Largest and smallest of the three color channels.
	always_comb begin
		hi = ch0;
		lo = ch0;
		if (ch1 > hi) hi = ch1;
		if (ch2 > hi) hi = ch2;
		if (ch1 < lo) lo = ch1;
		if (ch2 < lo) lo = ch2;
	end

	// Every trait is a quotient; unused selectors divide zero by one.
	always_comb begin
		num  = '0;
		den  = pte_pkg::DEN_ONE;
		flag = 1'b0;
		unique case (sel)
			pte_pkg::TRAIT_CH0: begin
				num = pte_pkg::NUM_W'(ch0);
				den = pte_pkg::DEN_CH;
			end
			pte_pkg::TRAIT_CH1: begin
				num = pte_pkg::NUM_W'(ch1);
				den = pte_pkg::DEN_CH;
			end
			pte_pkg::TRAIT_CH2: begin
				num = pte_pkg::NUM_W'(ch2);
				den = pte_pkg::DEN_CH;
			end
			pte_pkg::TRAIT_CH3: begin
				num = pte_pkg::NUM_W'(ch3);
				den = pte_pkg::DEN_CH;
			end
			pte_pkg::TRAIT_GA: begin
				num = pte_pkg::NUM_W'(ch0) + pte_pkg::NUM_W'(ch1);
				den = pte_pkg::DEN_GA;
			end
			pte_pkg::TRAIT_RGB: begin
				num = pte_pkg::NUM_W'(ch0) + pte_pkg::NUM_W'(ch1)
					+ pte_pkg::NUM_W'(ch2);
				den = pte_pkg::DEN_RGB;
			end
			pte_pkg::TRAIT_RGBA: begin
				num = pte_pkg::NUM_W'(ch0) + pte_pkg::NUM_W'(ch1)
					+ pte_pkg::NUM_W'(ch2) + pte_pkg::NUM_W'(ch3);
				den = pte_pkg::DEN_RGBA;
			end
			pte_pkg::TRAIT_LIT: begin
				num = pte_pkg::NUM_W'(hi) + pte_pkg::NUM_W'(lo);
				den = pte_pkg::DEN_LIT;
			end
			pte_pkg::TRAIT_SAT: begin
				// A black pixel has no defined saturation: zero over one, flagged.
				if (hi == '0) begin
					flag = 1'b1;
				end else begin
					num = pte_pkg::NUM_W'(hi - lo);
					den = pte_pkg::DEN_W'(hi);
				end
			end
			default: begin
				num = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dividend_s1 <= DW'(num) << FRAC_BITS;
			den_s1      <= den;
			ctl_s1      <= '{flag: flag, last: last_pixel};
		end
	end

endmodule

// ----- design/pte_div_stage.sv -----
module pte_div_stage #(
	parameter int DW = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic [pte_pkg::DEN_W-1:0]   rem_in,
	input  logic [DW-1:0]               dq_in,
	input  logic [pte_pkg::DEN_W-1:0]   den_in,
	input  pte_pkg::ctl_t               ctl_in,
	output logic                        valid_q,
	output logic [pte_pkg::DEN_W-1:0]   rem_q,
	output logic [DW-1:0]               dq_q,
	output logic [pte_pkg::DEN_W-1:0]   den_q,
	output pte_pkg::ctl_t               ctl_q
);

	logic [pte_pkg::DEN_W-1:0] rem;
	logic [DW-1:0]             dq;
	logic [pte_pkg::DEN_W:0]   trial;
	logic [pte_pkg::DEN_W:0]   diff;

	// Restoring division, DIV_BPS bits per stage. The dividend leaves dq at the
	// top while quotient bits enter at the bottom. The remainder stays below
	// the denominator, so the trial, twice the remainder plus the next dividend
	// bit, fits in one bit more than the remainder and never overflows.
	always_comb begin
		rem   = rem_in;
		dq    = dq_in;
		trial = '0;
		diff  = '0;
		for (int i = 0; i < pte_pkg::DIV_BPS; i++) begin
			trial = {rem, dq[DW-1]};
			dq    = {dq[DW-2:0], 1'b0};
			diff  = trial - {1'b0, den_in};
			if (trial >= {1'b0, den_in}) begin
				rem   = diff[pte_pkg::DEN_W-1:0];
				dq[0] = 1'b1;
			end else begin
				rem = trial[pte_pkg::DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_q <= rem;
			dq_q  <= dq;
			den_q <= den_in;
			ctl_q <= ctl_in;
		end
	end

endmodule

// ----- design/pte_sat.sv -----
module pte_sat #(
	parameter int DW = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic [DW-1:0]               quot_in,
	input  pte_pkg::ctl_t               ctl_in,
	output logic                        valid_q,
	output logic [pte_pkg::OUT_W-1:0]   value_q,
	output pte_pkg::ctl_t               ctl_q
);

	localparam int CW = (DW > pte_pkg::OUT_W) ? DW : pte_pkg::OUT_W;

	logic [CW-1:0]              quot_ext;
	logic [pte_pkg::OUT_W-1:0]  value;

	// Quotients too large for the result field clamp to all ones.
	always_comb begin
		quot_ext = CW'(quot_in);
		if (quot_ext > CW'(pte_pkg::OUT_MAX)) begin
			value = pte_pkg::OUT_MAX;
		end else begin
			value = quot_ext[pte_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q <= value;
			ctl_q   <= ctl_in;
		end
	end

endmodule

// ----- design/pixel_trait_extract.sv -----
// Pixel trait extractor. Each input word carries one 4-byte pixel and yields
// exactly one output word holding the trait picked by the trait_select
// register: a single channel over 255, the unnormalized GA, RGB or RGBA
// average, HSL lightness (max+min)/510 or HSV saturation (max-min)/max over
// the first three channels. Values are unsigned fixed point with FRAC_BITS
// fraction bits, truncated, and clamp to all ones if they do not fit in 24
// bits. Saturation of a black pixel returns zero with the tuser flag set;
// selector codes above 8 return zero. The last-pixel marker rides along on
// tlast. The block takes one pixel per clock and keeps that rate for as long
// as the output side accepts. It has one operand stage, a pipelined restoring
// divider of STAGES = ceil((10 + FRAC_BITS) / 4) stages that resolves four
// quotient bits per stage, and the output register that clamps the quotient.
// Each stage holds its word only while the stage behind it is full and
// stalled, so bubbles close up and new pixels keep entering while a result
// waits. Write trait_select only while no pixel is in flight.
module pixel_trait_extract #(
	parameter int FRAC_BITS = pte_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: trait_select.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pte_pkg::SEL_W-1:0]     cfg_data,
	// Pixel input. tdata fields from bit 0: ch0, ch1, ch2, ch3.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [4*pte_pkg::CH_W-1:0]    s_tdata,
	input  logic                          s_tlast,
	// Trait output. tdata fields from bit 0: trait_value.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pte_pkg::OUT_W-1:0]     m_tdata,
	// tuser fields from bit 0: undefined_ratio.
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int STAGES = (pte_pkg::NUM_W + FRAC_BITS + pte_pkg::DIV_BPS - 1)
		/ pte_pkg::DIV_BPS;
	localparam int DW = STAGES * pte_pkg::DIV_BPS;

	logic [pte_pkg::SEL_W-1:0] trait_select_q;

	// Pipeline signals; index 0 is the operand stage, 1..STAGES the divider.
	logic                       valid_a    [0:STAGES];
	logic [pte_pkg::DEN_W-1:0]  rem_a      [0:STAGES];
	logic [DW-1:0]              dq_a       [0:STAGES];
	logic [pte_pkg::DEN_W-1:0]  den_a      [0:STAGES];
	pte_pkg::ctl_t              ctl_a      [0:STAGES];
	// Ready of each stage; index STAGES+1 is the output register.
	logic                       rdy        [0:STAGES+1];
	logic [STAGES:0]            valid_vec;
	pte_pkg::ctl_t              ctl_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trait_select_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			trait_select_q <= cfg_data;
		end
	end

	// A stage may load when it is empty or its word moves on this cycle.
	assign rdy[STAGES+1] = !m_tvalid || m_tready;
	for (genvar k = 0; k <= STAGES; k++) begin : g_rdy
		assign rdy[k]       = !valid_a[k] || rdy[k+1];
		assign valid_vec[k] = valid_a[k];
	end

	assign s_tready = rdy[0];

	pte_prep #(
		.FRAC_BITS (FRAC_BITS),
		.DW        (DW)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (rdy[0]),
		.in_valid    (s_tvalid),
		.ch0         (s_tdata[pte_pkg::CH_W-1:0]),
		.ch1         (s_tdata[2*pte_pkg::CH_W-1:pte_pkg::CH_W]),
		.ch2         (s_tdata[3*pte_pkg::CH_W-1:2*pte_pkg::CH_W]),
		.ch3         (s_tdata[4*pte_pkg::CH_W-1:3*pte_pkg::CH_W]),
		.last_pixel  (s_tlast),
		.sel         (trait_select_q),
		.valid_s1    (valid_a[0]),
		.dividend_s1 (dq_a[0]),
		.den_s1      (den_a[0]),
		.ctl_s1      (ctl_a[0])
	);

	// The remainder starts at zero for every word.
	assign rem_a[0] = '0;

	for (genvar k = 1; k <= STAGES; k++) begin : g_div
		pte_div_stage #(
			.DW (DW)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (rdy[k]),
			.in_valid (valid_a[k-1]),
			.rem_in   (rem_a[k-1]),
			.dq_in    (dq_a[k-1]),
			.den_in   (den_a[k-1]),
			.ctl_in   (ctl_a[k-1]),
			.valid_q  (valid_a[k]),
			.rem_q    (rem_a[k]),
			.dq_q     (dq_a[k]),
			.den_q    (den_a[k]),
			.ctl_q    (ctl_a[k])
		);
	end

	pte_sat #(
		.DW (DW)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (rdy[STAGES+1]),
		.in_valid (valid_a[STAGES]),
		.quot_in  (dq_a[STAGES]),
		.ctl_in   (ctl_a[STAGES]),
		.valid_q  (m_tvalid),
		.value_q  (m_tdata),
		.ctl_q    (ctl_out)
	);

	assign m_tuser = ctl_out.flag;
	assign m_tlast = ctl_out.last;

	// A flagged black pixel always carries a zero trait.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("flagged word with nonzero trait value");

	// With every stage full and the output stalled, no pixel may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && (&valid_vec) |-> !s_tready)
		else $error("pixel accepted into a full, stalled pipeline");

	// An empty operand stage must always take a pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_a[0] |-> s_tready)
		else $error("input stalled with empty operand stage");

endmodule
